### rtl/bws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_pkg
// Shared types and constants of the batch window segmenter.
// ----------------------------------------------------------------------------
package bws_pkg;

  localparam int LEN_W = 24;
  localparam int WIN_W = 32;
  localparam int IDX_W = 12;
  localparam int WCNT_W = 16;

  // Smallest usable window, and the window size after reset.
  localparam logic [WIN_W-1:0] WINDOW_FLOOR = 32'd524288;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1048576;

  // Working state of one step, fed to the step unit.
  typedef struct packed {
    logic [WIN_W-1:0] fill;
    logic [WIN_W-1:0] win;
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] off;
    logic             last;
  } bws_step_in_t;

  // Outcome of one step.
  typedef struct packed {
    logic             emit;
    logic             wend;
    logic             more;
    logic [LEN_W-1:0] take;
    logic [LEN_W-1:0] rem_next;
    logic [LEN_W-1:0] off_next;
    logic [WIN_W-1:0] fill_add;
  } bws_step_out_t;

endpackage

### rtl/bws_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_item_if
// Request channel carrying one batch item length.
// ----------------------------------------------------------------------------
interface bws_item_if;
  logic        valid;
  logic        ready;
  logic [23:0] item_bytes;
  logic        last_item;

  modport source (output valid, output item_bytes, output last_item, input ready);
  modport sink (input valid, input item_bytes, input last_item, output ready);
endinterface

### rtl/bws_part_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_part_if
// Request channel carrying one copy part.
// ----------------------------------------------------------------------------
interface bws_part_if;
  logic        valid;
  logic        ready;
  logic [11:0] item_index;
  logic [23:0] item_offset;
  logic [23:0] part_bytes;
  logic [31:0] packed_offset;
  logic        window_end;
  logic [15:0] window_index;
  logic        last_of_run;

  modport source (
    output valid, output item_index, output item_offset, output part_bytes,
    output packed_offset, output window_end, output window_index,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input item_index, input item_offset, input part_bytes,
    input packed_offset, input window_end, input window_index,
    input last_of_run, output ready
  );
endinterface

### rtl/bws_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_step_unit
// Combinational room/take unit: cuts the next part off the remaining item bytes.
// ----------------------------------------------------------------------------
module bws_step_unit (
  input  bws_pkg::bws_step_in_t  st,
  output bws_pkg::bws_step_out_t res
);
  import bws_pkg::*;

  logic             marker;
  logic [WIN_W-1:0] room;
  logic [LEN_W-1:0] take;
  logic [WIN_W-1:0] fill_add;
  logic [LEN_W-1:0] rem_next;

  always_comb begin
    // Close a full or overfull window, or an open window on an empty last item.
    marker   = (st.fill >= st.win) || (st.rem == '0 && st.last && st.fill != '0);
    room     = st.win - st.fill;
    if (marker) begin
      take = '0;
    end else if ({{(WIN_W-LEN_W){1'b0}}, st.rem} < room) begin
      take = st.rem;
    end else begin
      take = room[LEN_W-1:0];
    end
    fill_add = st.fill + {{(WIN_W-LEN_W){1'b0}}, take};
    rem_next = st.rem - take;

    res.emit     = marker || (st.rem != '0);
    res.take     = take;
    res.rem_next = rem_next;
    res.off_next = st.off + take;
    res.fill_add = fill_add;
    res.wend     = marker || (fill_add == st.win) || (rem_next == '0 && st.last);
    res.more     = (rem_next != '0);
  end

endmodule

### rtl/batch_window_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_window_segmenter
// Packs batch item lengths into windows of at most window_bytes and emits
// the copy parts of each item.
//
// An item is accepted while idle and then walked by a single step unit that
// cuts one part per cycle while the output register is free or being read;
// the input stays stalled until the item's last part is loaded, or, for an
// item with no parts, until the step unit finds nothing to emit. The next item
// may be accepted while the final part still waits in the output register.
// window_bytes below 524288 acts as 524288 and may be written only while idle.
// ----------------------------------------------------------------------------
module batch_window_segmenter #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               window_we,
  input  logic [31:0]        window_wdata,
  bws_item_if.sink           item,
  bws_part_if.source         part
);
  import bws_pkg::*;

  localparam int CNT_W = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state;
  logic [WIN_W-1:0]  window_bytes;
  logic [WIN_W-1:0]  win;
  logic [WIN_W-1:0]  fill;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  off;
  logic              last;
  logic [CNT_W-1:0]  item_cnt;
  logic [WCNT_W-1:0] win_cnt;
  logic [CNT_W+IDX_W-1:0] idx_ext;

  bws_step_in_t  st;
  bws_step_out_t res;

  logic out_valid;
  logic load;
  logic advance;
  logic finish;

  assign win = (window_bytes < WINDOW_FLOOR) ? WINDOW_FLOOR : window_bytes;
  assign idx_ext = {{IDX_W{1'b0}}, item_cnt};

  always_comb begin
    st.fill = fill;
    st.win  = win;
    st.rem  = rem;
    st.off  = off;
    st.last = last;
  end

  bws_step_unit u_step (
    .st  (st),
    .res (res)
  );

  // Load a part when the output register is free; with nothing to emit, finish.
  assign load    = (state == ST_RUN) && res.emit && (!out_valid || part.ready);
  assign advance = load || ((state == ST_RUN) && !res.emit);
  assign finish  = advance && (!res.emit || !res.more);

  assign item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes <= WINDOW_RESET;
    end else if (window_we) begin
      window_bytes <= window_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      item_cnt <= '0;
      win_cnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (finish && last) begin
            // Batch end: restart counters and window
            state    <= ST_IDLE;
            item_cnt <= '0;
            win_cnt  <= '0;
            fill     <= '0;
          end else begin
            if (load) begin
              if (res.wend) begin
                fill    <= '0;
                win_cnt <= win_cnt + 1'b1;
              end else begin
                fill <= res.fill_add;
              end
            end
            if (finish) begin
              state    <= ST_IDLE;
              item_cnt <= (item_cnt == CNT_MAX) ? '0 : item_cnt + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      rem  <= item.item_bytes;
      off  <= '0;
      last <= item.last_item;
    end else if (load) begin
      rem <= res.rem_next;
      off <= res.off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (part.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part.item_index    <= idx_ext[IDX_W-1:0];
      part.item_offset   <= off;
      part.part_bytes    <= res.take;
      part.packed_offset <= fill;
      part.window_end    <= res.wend;
      part.window_index  <= win_cnt;
      part.last_of_run   <= !res.more;
    end
  end

  assign part.valid = out_valid;

  // A zero-size part is only ever a window-closing marker.
  a_marker_closes: assert property (@(posedge clk) disable iff (rst)
    part.valid && part.part_bytes == '0 |-> part.window_end && part.item_offset == '0)
    else $error("zero-size part that does not close its window");

  // A part never runs past the end of its window.
  a_part_fits: assert property (@(posedge clk) disable iff (rst)
    part.valid && part.part_bytes != '0 |->
      ({1'b0, part.packed_offset} + {9'b0, part.part_bytes}) <= {1'b0, win})
    else $error("part overruns the window");

  // Accepting an item takes the sequencer out of idle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("input still ready after accepting an item");

endmodule
